// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this project.
// Each macro expands to one labeled concurrent assertion on clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds as well.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wrbe_pkg.sv =====
// Package for the watch report to input events block: types, codes and constants.
// Used by every other file of the block; depends on nothing.
`timescale 1ns / 1ps

package wrbe_pkg;

	// Widths of the report and event fields.
	localparam int BYTE_W  = 8;
	localparam int GAIN_W  = 16;
	localparam int VALUE_W = 24;
	localparam int KIND_W  = 2;
	localparam int CODE_W  = 2;
	localparam int CNT_W   = 5;
	localparam int IDX_W   = 3;

	// Debounce limit default and depth of the command queue.
	localparam int DEBOUNCE_LIMIT_DEF = 20;
	localparam int QUEUE_DEPTH        = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ABS_MODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_SWAP_X_Z = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN_Z   = 3'd4;

	// Gain reset value, 1.0 in Q8.8.
	localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd256;

	// Status codes of the report.
	localparam logic signed [BYTE_W-1:0] STATUS_MOTION = 8'sd1;
	localparam logic signed [BYTE_W-1:0] BTN1_CODE_A   = 8'sd17;
	localparam logic signed [BYTE_W-1:0] BTN1_CODE_B   = 8'sd18;
	localparam logic signed [BYTE_W-1:0] BTN2_CODE_A   = 8'sd49;
	localparam logic signed [BYTE_W-1:0] BTN2_CODE_B   = 8'sd50;
	localparam logic signed [BYTE_W-1:0] BTN3_CODE_A   = 8'sd33;
	localparam logic signed [BYTE_W-1:0] BTN3_CODE_B   = 8'sd34;

	// Button indexes.
	localparam logic [CODE_W-1:0] BTN_NONE = 2'd0;
	localparam logic [CODE_W-1:0] BTN_1    = 2'd1;
	localparam logic [CODE_W-1:0] BTN_2    = 2'd2;
	localparam logic [CODE_W-1:0] BTN_3    = 2'd3;

	// Event kinds.
	localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REL    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ABS    = 2'd3;

	// Axis codes.
	localparam logic [CODE_W-1:0] AXIS_X = 2'd0;
	localparam logic [CODE_W-1:0] AXIS_Y = 2'd1;
	localparam logic [CODE_W-1:0] AXIS_Z = 2'd2;

	// What the back end has to do for one report.
	typedef enum logic [2:0] {
		OP_SYNC_ONLY,
		OP_RELEASE,
		OP_PRESS,
		OP_REL,
		OP_ABS
	} op_t;

	// One classified report, as it waits in the queue.
	typedef struct packed {
		op_t                       op;
		logic [CODE_W-1:0]         button;
		logic signed [BYTE_W-1:0]  ax;
		logic signed [BYTE_W-1:0]  ay;
		logic signed [BYTE_W-1:0]  az;
	} cmd_t;

	// Configuration register contents.
	typedef struct packed {
		logic                      abs_mode;
		logic                      swap_x_z;
		logic signed [GAIN_W-1:0]  gain_x;
		logic signed [GAIN_W-1:0]  gain_y;
		logic signed [GAIN_W-1:0]  gain_z;
	} cfg_t;

endpackage

// ===== sv/wrbe_if.sv =====
// Channel interfaces of the watch report to input events block: reports, events, config.
// Depends on wrbe_pkg for field widths.
`timescale 1ns / 1ps

// Report channel: one watch report per beat.
interface wrbe_report_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [wrbe_pkg::BYTE_W-1:0]  status_code;
	logic signed [wrbe_pkg::BYTE_W-1:0]  axis_y_raw;
	logic signed [wrbe_pkg::BYTE_W-1:0]  axis_x_raw;
	logic signed [wrbe_pkg::BYTE_W-1:0]  axis_z_raw;

	modport source (output valid, status_code, axis_y_raw, axis_x_raw, axis_z_raw,
		input ready);
	modport sink (input valid, status_code, axis_y_raw, axis_x_raw, axis_z_raw,
		output ready);
endinterface

// Event channel: one input event per beat.
interface wrbe_event_if;
	logic                                 valid;
	logic                                 ready;
	logic [wrbe_pkg::KIND_W-1:0]         event_kind;
	logic [wrbe_pkg::CODE_W-1:0]         event_code;
	logic signed [wrbe_pkg::VALUE_W-1:0] event_value;
	logic                                 last_event;

	modport source (output valid, event_kind, event_code, event_value, last_event,
		input ready);
	modport sink (input valid, event_kind, event_code, event_value, last_event,
		output ready);
endinterface

// Configuration write channel: one register write per beat.
interface wrbe_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [wrbe_pkg::IDX_W-1:0]          index;
	logic [wrbe_pkg::GAIN_W-1:0]         data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/wrbe_front.sv =====
// Front end: accepts reports, tracks the held button and debounce counter, and
// classifies each report into a command for the queue. Depends on wrbe_pkg, wrbe_if.
`timescale 1ns / 1ps

module wrbe_front #(
	parameter int DEBOUNCE_LIMIT = wrbe_pkg::DEBOUNCE_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	wrbe_report_if.sink         rpt,
	input  wrbe_pkg::cfg_t      cfg,
	input  logic                q_full,
	output logic                push,
	output wrbe_pkg::cmd_t      push_cmd
);
	import wrbe_pkg::*;

	logic [CODE_W-1:0] held_q;
	logic [CNT_W-1:0]  dbc_q;
	logic [CODE_W-1:0] held_n;
	logic [CNT_W-1:0]  cnt_base;
	logic              press;
	logic [CODE_W-1:0] btn_dec;

	// A report is taken whenever the queue has room.
	assign rpt.ready = !q_full;
	assign push      = rpt.valid && rpt.ready;

	// Decode the status byte into a button index; unknown codes give button 0.
	always_comb begin
		unique case (rpt.status_code) inside
			BTN1_CODE_A, BTN1_CODE_B: btn_dec = BTN_1;
			BTN2_CODE_A, BTN2_CODE_B: btn_dec = BTN_2;
			BTN3_CODE_A, BTN3_CODE_B: btn_dec = BTN_3;
			default:                  btn_dec = BTN_NONE;
		endcase
	end

	// Classify the report in priority order: release, press, motion, nothing.
	always_comb begin
		push_cmd.op     = OP_SYNC_ONLY;
		push_cmd.button = held_q;
		push_cmd.ax     = rpt.axis_x_raw;
		push_cmd.ay     = rpt.axis_y_raw;
		push_cmd.az     = rpt.axis_z_raw;
		held_n          = held_q;
		press           = 1'b0;
		if (held_q != BTN_NONE) begin
			push_cmd.op = OP_RELEASE;
			held_n      = BTN_NONE;
		end else if (rpt.status_code > STATUS_MOTION && dbc_q == '0) begin
			push_cmd.op     = OP_PRESS;
			push_cmd.button = btn_dec;
			held_n          = btn_dec;
			press           = 1'b1;
		end else if (rpt.status_code == STATUS_MOTION) begin
			if (cfg.abs_mode) begin
				push_cmd.op = OP_ABS;
				if (cfg.swap_x_z) begin
					push_cmd.ax = rpt.axis_z_raw;
					push_cmd.az = rpt.axis_x_raw;
				end
			end else begin
				push_cmd.op = OP_REL;
			end
		end
	end

	// A press starts the counter at one; it then steps once per report.
	assign cnt_base = press ? CNT_W'(1) : dbc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= BTN_NONE;
			dbc_q  <= '0;
		end else if (push) begin
			held_q <= held_n;
			if (cnt_base == '0 || cnt_base >= CNT_W'(DEBOUNCE_LIMIT)) begin
				dbc_q <= '0;
			end else begin
				dbc_q <= cnt_base + CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/wrbe_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on wrbe_pkg for the command type and the queue depth.
`timescale 1ns / 1ps

module wrbe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wrbe_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output wrbe_pkg::cmd_t    head
);
	import wrbe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	cmd_t               entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;

	assign full       = count_q == CNT_QW'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];

	// Entry storage; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// ===== sv/wrbe_back.sv =====
// Back end: expands each queued command into events, one per cycle unless stalled,
// with axis scaling multiplier before output register. Depends on wrbe_pkg, wrbe_if.
`timescale 1ns / 1ps

module wrbe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wrbe_pkg::cfg_t    cfg,
	input  logic              head_valid,
	input  wrbe_pkg::cmd_t    head,
	output logic              pop,
	wrbe_event_if.source      evt
);
	import wrbe_pkg::*;

	logic [1:0]                 idx_q;
	logic                       out_valid_q;
	logic [KIND_W-1:0]          kind_q;
	logic [CODE_W-1:0]          code_q;
	logic signed [VALUE_W-1:0]  value_q;
	logic                       last_q;

	logic                       load;
	logic [1:0]                 n_pre;
	logic                       is_sync;
	logic signed [BYTE_W-1:0]   raw;
	logic signed [GAIN_W-1:0]   gain;
	logic signed [VALUE_W-1:0]  prod;
	logic signed [VALUE_W-1:0]  prod_div;
	logic [KIND_W-1:0]          kind_n;
	logic [CODE_W-1:0]          code_n;
	logic signed [VALUE_W-1:0]  value_n;

	// Load a new event when the output register is empty or being drained.
	assign load = head_valid && (!out_valid_q || evt.ready);

	// Number of events ahead of the closing sync.
	always_comb begin
		unique case (head.op) inside
			OP_RELEASE, OP_PRESS: n_pre = 2'd1;
			OP_REL:               n_pre = 2'd2;
			OP_ABS:               n_pre = 2'd3;
			default:              n_pre = 2'd0;
		endcase
	end

	assign is_sync = idx_q == n_pre;
	assign pop     = load && is_sync;

	// Axis select and scaling; the event index doubles as the axis code.
	always_comb begin
		case (idx_q)
			AXIS_X: begin
				raw  = head.ax;
				gain = cfg.gain_x;
			end
			AXIS_Y: begin
				raw  = head.ay;
				gain = cfg.gain_y;
			end
			default: begin
				raw  = head.az;
				gain = cfg.gain_z;
			end
		endcase
	end

	// Both operands are sign-extended to the event width; the full product fits.
	assign prod = VALUE_W'(raw) * VALUE_W'(gain);

	// Divide by 256 with truncation toward zero: bias negative products first.
	assign prod_div = (prod + (prod[VALUE_W-1] ? VALUE_W'(255) : VALUE_W'(0))) >>> 8;

	// Event fields for the current index.
	always_comb begin
		kind_n  = KIND_SYNC;
		code_n  = '0;
		value_n = '0;
		if (!is_sync) begin
			unique case (head.op)
				OP_RELEASE: begin
					kind_n = KIND_BUTTON;
					code_n = head.button;
				end
				OP_PRESS: begin
					kind_n  = KIND_BUTTON;
					code_n  = head.button;
					value_n = VALUE_W'(1);
				end
				OP_REL: begin
					kind_n  = KIND_REL;
					code_n  = idx_q;
					value_n = prod_div;
				end
				OP_ABS: begin
					kind_n  = KIND_ABS;
					code_n  = idx_q;
					value_n = prod;
				end
				default: begin
					kind_n = KIND_SYNC;
				end
			endcase
		end
	end

	// Event index within the current command and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= is_sync ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_n;
			code_q  <= code_n;
			value_q <= value_n;
			last_q  <= is_sync;
		end
	end

	assign evt.valid       = out_valid_q;
	assign evt.event_kind  = kind_q;
	assign evt.event_code  = code_q;
	assign evt.event_value = value_q;
	assign evt.last_event  = last_q;

endmodule

// ===== sv/watch_report_to_input_events.sv =====
// Watch report to input events: takes accelerometer watch reports and gives input
// events, each report ending in a sync event. Depends on wrbe_pkg, wrbe_if and the
// front end, queue and back end modules.
//
// A report is accepted whenever the two-entry command queue has room; the events
// leave one per cycle while the event side is ready, from a single output register,
// which holds one event at a time. A report gives one event for a lone sync, two for
// a button press or release, three for mouse motion and four for joystick motion.
// The first event of a report passes through a command queue entry and then the
// output register before it appears at the output, and is held there until taken.
// Configuration writes are taken in every cycle and must only be made while the
// block is idle.
`timescale 1ns / 1ps

module watch_report_to_input_events #(
	parameter int DEBOUNCE_LIMIT = wrbe_pkg::DEBOUNCE_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wrbe_report_if.sink   rpt,
	wrbe_event_if.source  evt,
	wrbe_cfg_if.sink      cfg
);
	import wrbe_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	cmd_t  push_cmd;
	logic  q_full;
	logic  pop;
	logic  head_valid;
	cmd_t  head;

	// Configuration registers; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.abs_mode <= 1'b0;
			cfg_q.swap_x_z <= 1'b0;
			cfg_q.gain_x   <= GAIN_ONE;
			cfg_q.gain_y   <= GAIN_ONE;
			cfg_q.gain_z   <= GAIN_ONE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ABS_MODE: cfg_q.abs_mode <= cfg.data[0];
				REG_SWAP_X_Z: cfg_q.swap_x_z <= cfg.data[0];
				REG_GAIN_X:   cfg_q.gain_x   <= cfg.data;
				REG_GAIN_Y:   cfg_q.gain_y   <= cfg.data;
				REG_GAIN_Z:   cfg_q.gain_z   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Front end: classification and button state.
	wrbe_front #(
		.DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rpt      (rpt),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Command queue.
	wrbe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: event generation.
	wrbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.evt        (evt)
	);

endmodule

// ===== sv/wrbe_checker.sv =====
// Port-level checker for the watch report to input events block, with its bind.
// Depends on wrbe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wrbe_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 evt_valid,
	input  logic                                 evt_ready,
	input  logic [wrbe_pkg::KIND_W-1:0]         evt_kind,
	input  logic [wrbe_pkg::CODE_W-1:0]         evt_code,
	input  logic signed [wrbe_pkg::VALUE_W-1:0] evt_value,
	input  logic                                 evt_last
);
	import wrbe_pkg::*;

	// A waiting beat stays offered until it is taken.
	`ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid, "event beat dropped while stalled")

	// The closing beat is always a blank sync.
	`ASSERT_IMPLY(a_last_is_sync, evt_valid && evt_last, evt_kind == KIND_SYNC && evt_code == '0 && evt_value == '0, "last event is not a blank sync")

	// Every sync closes its report.
	`ASSERT_IMPLY(a_sync_is_last, evt_valid && evt_kind == KIND_SYNC, evt_last, "sync event not marked last")

	// Button events carry only press or release values.
	`ASSERT_IMPLY(a_button_value, evt_valid && evt_kind == KIND_BUTTON, evt_value == VALUE_W'(0) || evt_value == VALUE_W'(1), "button event with bad value")

endmodule

bind watch_report_to_input_events wrbe_checker u_wrbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.evt_kind  (evt.event_kind),
	.evt_code  (evt.event_code),
	.evt_value (evt.event_value),
	.evt_last  (evt.last_event)
);

// ===== test/tb_watch_report_to_input_events.sv =====
// Testbench for watch_report_to_input_events: sends watch reports, predicts the input
// events of each one and checks every event beat. Depends on wrbe_pkg, wrbe_if and the RTL.
`timescale 1ns / 1ps

module tb_watch_report_to_input_events;
	import wrbe_pkg::*;

	localparam int DEB_LIMIT    = DEBOUNCE_LIMIT_DEF;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_SHOWN    = 10;

	// One expected or observed event beat.
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [CODE_W-1:0]         code;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} input_event_t;

	logic clk;
	logic arst_n;

	wrbe_report_if rpt_if ();
	wrbe_event_if  evt_if ();
	wrbe_cfg_if    cfg_if ();

	watch_report_to_input_events #(
		.DEBOUNCE_LIMIT(DEB_LIMIT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rpt   (rpt_if.sink),
		.evt   (evt_if.source),
		.cfg   (cfg_if.sink)
	);

	// Predictor copy of the configuration and of the button state.
	cfg_t               pred_cfg;
	logic [CODE_W-1:0]  held_btn;
	logic [CNT_W-1:0]   deb_cnt;

	input_event_t pending_events[$];
	int mismatch_count = 0;
	int events_checked = 0;
	int reports_sent   = 0;
	int hold_request   = 0;
	bit no_gaps        = 1'b0;

	// Clock: 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Records one failure; only the first MAX_SHOWN failures are printed.
	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_SHOWN) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	function automatic void queue_event(input logic [KIND_W-1:0] kind,
		input logic [CODE_W-1:0] code, input int value, input logic last);
		input_event_t e;
		e.kind  = kind;
		e.code  = code;
		e.value = VALUE_W'(value);
		e.last  = last;
		pending_events.push_back(e);
	endfunction

	// Works out the events of one accepted report and steps the button state.
	function automatic void predict_report_events(input logic signed [BYTE_W-1:0] st,
		input logic signed [BYTE_W-1:0] ay, input logic signed [BYTE_W-1:0] ax,
		input logic signed [BYTE_W-1:0] az);
		int s, x, y, z, t, gx, gy, gz;
		logic [CODE_W-1:0] btn;
		s  = st;
		x  = ax;
		y  = ay;
		z  = az;
		gx = pred_cfg.gain_x;
		gy = pred_cfg.gain_y;
		gz = pred_cfg.gain_z;
		if (held_btn != BTN_NONE) begin
			// A held button is released and the rest of the report is dropped.
			queue_event(KIND_BUTTON, held_btn, 0, 1'b0);
			held_btn = BTN_NONE;
		end else if (s > 1 && deb_cnt == 0) begin
			btn = BTN_NONE;
			if (st == BTN1_CODE_A || st == BTN1_CODE_B) begin
				btn = BTN_1;
			end else if (st == BTN2_CODE_A || st == BTN2_CODE_B) begin
				btn = BTN_2;
			end else if (st == BTN3_CODE_A || st == BTN3_CODE_B) begin
				btn = BTN_3;
			end
			queue_event(KIND_BUTTON, btn, 1, 1'b0);
			held_btn = btn;
			deb_cnt  = 1;
		end else if (s == 1) begin
			if (!pred_cfg.abs_mode) begin
				// SV integer division truncates toward zero.
				queue_event(KIND_REL, AXIS_X, (x * gx) / 256, 1'b0);
				queue_event(KIND_REL, AXIS_Y, (y * gy) / 256, 1'b0);
			end else begin
				if (pred_cfg.swap_x_z) begin
					t = x;
					x = z;
					z = t;
				end
				queue_event(KIND_ABS, AXIS_X, x * gx, 1'b0);
				queue_event(KIND_ABS, AXIS_Y, y * gy, 1'b0);
				queue_event(KIND_ABS, AXIS_Z, z * gz, 1'b0);
			end
		end
		queue_event(KIND_SYNC, CODE_W'(0), 0, 1'b1);
		if (deb_cnt != 0) begin
			deb_cnt = (deb_cnt >= DEB_LIMIT) ? CNT_W'(0) : deb_cnt + 1'b1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 25);
	endfunction

	function automatic logic signed [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'sh80;
			1: return 8'sh7f;
			2: return 8'sh00;
			3: return 8'shff;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic signed [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return GAIN_ONE;
			default: return GAIN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Offers one report beat after a random gap; valid stays high for a following beat.
	task automatic send_report(input logic signed [BYTE_W-1:0] st,
		input logic signed [BYTE_W-1:0] ay, input logic signed [BYTE_W-1:0] ax,
		input logic signed [BYTE_W-1:0] az);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rpt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rpt_if.valid       <= 1'b1;
		rpt_if.status_code <= st;
		rpt_if.axis_y_raw  <= ay;
		rpt_if.axis_x_raw  <= ax;
		rpt_if.axis_z_raw  <= az;
		do @(posedge clk); while (rpt_if.ready !== 1'b1);
		predict_report_events(st, ay, ax, az);
		reports_sent++;
	endtask

	// Mostly motion and button codes with random content, the rest is noise.
	task automatic send_random_report();
		int pick;
		logic signed [BYTE_W-1:0] st;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			st = STATUS_MOTION;
		end else if (pick < 65) begin
			case ($urandom_range(0, 5))
				0: st = BTN1_CODE_A;
				1: st = BTN1_CODE_B;
				2: st = BTN2_CODE_A;
				3: st = BTN2_CODE_B;
				4: st = BTN3_CODE_A;
				default: st = BTN3_CODE_B;
			endcase
		end else if (pick < 75) begin
			st = BYTE_W'($urandom_range(2, 127));
		end else if (pick < 85) begin
			st = BYTE_W'($urandom_range(128, 256));
		end else begin
			st = BYTE_W'($urandom_range(0, 255));
		end
		send_report(st, rand_byte(), rand_byte(), rand_byte());
	endtask

	// Stops offering reports and waits until every expected event has arrived.
	task automatic wait_drained();
		rpt_if.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		case (idx)
			REG_ABS_MODE: pred_cfg.abs_mode = val[0];
			REG_SWAP_X_Z: pred_cfg.swap_x_z = val[0];
			REG_GAIN_X:   pred_cfg.gain_x   = val;
			REG_GAIN_Y:   pred_cfg.gain_y   = val;
			REG_GAIN_Z:   pred_cfg.gain_z   = val;
			default: ;
		endcase
	endtask

	// Rewrites every register while the block is idle; a stray index may follow.
	task automatic configure(input bit joy, input bit swap,
		input logic signed [GAIN_W-1:0] gx, input logic signed [GAIN_W-1:0] gy,
		input logic signed [GAIN_W-1:0] gz, input bit stray_write);
		wait_drained();
		write_reg(REG_ABS_MODE, {15'($urandom_range(0, 32767)), joy});
		write_reg(REG_SWAP_X_Z, {15'($urandom_range(0, 32767)), swap});
		write_reg(REG_GAIN_X, gx);
		write_reg(REG_GAIN_Y, gy);
		write_reg(REG_GAIN_Z, gz);
		if (stray_write) begin
			write_reg(IDX_W'(REG_GAIN_Z + $urandom_range(1, 3)),
				GAIN_W'($urandom_range(0, 65535)));
		end
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset settings: relative motion extremes, a press, its release and the debounce.
	task automatic test_mouse_defaults();
		send_report(STATUS_MOTION, 8'sh80, 8'sh7f, 8'sh00);
		send_report(STATUS_MOTION, 8'sh7f, 8'sh80, 8'shff);
		send_report(STATUS_MOTION, 8'sh00, 8'shff, 8'sh7f);
		send_report(8'sh00, 8'sh11, 8'sh22, 8'sh33);
		send_report(8'sh80, 8'sh7f, 8'sh7f, 8'sh7f);
		send_report(BTN1_CODE_A, 8'sh00, 8'sh00, 8'sh00);
		// The held button is released and the motion of this report is dropped.
		send_report(STATUS_MOTION, 8'sh40, 8'sh40, 8'sh40);
		// A button code while debouncing gives only the sync.
		send_report(BTN2_CODE_B, 8'sh00, 8'sh00, 8'sh00);
		send_report(STATUS_MOTION, 8'sh10, 8'shf0, 8'sh00);
	endtask

	// Absolute axes, with and without the X/Z swap, at unit gain and at gain extremes.
	task automatic test_joystick_axes();
		configure(1'b1, 1'b0, GAIN_ONE, GAIN_ONE, GAIN_ONE, 1'b1);
		send_report(STATUS_MOTION, 8'sh80, 8'sh7f, 8'sh80);
		configure(1'b1, 1'b1, 16'sh8000, 16'sh7fff, 16'sh0000, 1'b0);
		send_report(STATUS_MOTION, 8'sh80, 8'sh80, 8'sh7f);
		send_report(STATUS_MOTION, 8'sh7f, 8'sh01, 8'shff);
	endtask

	// Relative motion with extreme and tiny negative gains; truncation goes toward zero.
	task automatic test_mouse_gains();
		configure(1'b0, 1'b1, 16'sh8000, 16'shffff, 16'sh7fff, 1'b1);
		send_report(STATUS_MOTION, 8'sh80, 8'sh80, 8'sh05);
		send_report(STATUS_MOTION, 8'sh01, 8'sh01, 8'sh00);
		send_report(STATUS_MOTION, 8'shff, 8'sh7f, 8'sh80);
	endtask

	// An unknown code presses button 0, which is never released.
	task automatic test_unknown_code();
		while (deb_cnt != 0 || held_btn != BTN_NONE) begin
			send_report(8'sh00, rand_byte(), rand_byte(), rand_byte());
		end
		send_report(8'sh02, 8'sh00, 8'sh00, 8'sh00);
		send_report(STATUS_MOTION, 8'sh33, 8'shcc, 8'sh00);
		send_report(BTN3_CODE_B, 8'sh00, 8'sh00, 8'sh00);
		send_report(8'sh7f, 8'sh00, 8'sh00, 8'sh00);
	endtask

	// Several random settings, one of them without any idling.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: configure(1'b0, 1'($urandom), rand_gain(), rand_gain(), rand_gain(), 1'b0);
				1: configure(1'b1, 1'b0, rand_gain(), rand_gain(), rand_gain(), 1'b1);
				2: configure(1'b1, 1'b1, rand_gain(), rand_gain(), rand_gain(), 1'b0);
				default: configure(1'($urandom), 1'($urandom), rand_gain(), rand_gain(),
					rand_gain(), 1'($urandom));
			endcase
			no_gaps = (phase == 2);
			repeat (60) send_random_report();
		end
		no_gaps = 1'b0;
	endtask

	// The event side holds off for a long stretch while reports keep coming, then the
	// report side pauses until everything has drained.
	task automatic test_pressure();
		wait_drained();
		no_gaps      = 1'b1;
		hold_request = 150;
		repeat (30) send_random_report();
		no_gaps = 1'b0;
		wait_drained();
		repeat (10) send_random_report();
	endtask

	// Event side: random ready with short and long stalls, plus requested hold-offs.
	initial begin : event_sink
		int run_len;
		int stall_len;
		int pick;
		evt_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall_len    = hold_request;
				hold_request = 0;
				evt_if.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			evt_if.ready <= 1'b1;
			run_len = $urandom_range(1, 12);
			repeat (run_len) @(posedge clk);
			if (!no_gaps && hold_request == 0) begin
				pick = $urandom_range(0, 99);
				stall_len = (pick < 55) ? 0 : (pick < 93) ? $urandom_range(1, 3)
					: $urandom_range(10, 30);
				if (stall_len > 0) begin
					evt_if.ready <= 1'b0;
					repeat (stall_len) @(posedge clk);
				end
			end
		end
	end

	// Compares each event beat with the oldest expectation.
	always @(posedge clk) begin : event_checker
		input_event_t seen;
		input_event_t want;
		if (arst_n === 1'b1 && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
			seen.kind  = evt_if.event_kind;
			seen.code  = evt_if.event_code;
			seen.value = evt_if.event_value;
			seen.last  = evt_if.last_event;
			if (pending_events.size() == 0) begin
				note_failure($sformatf("unexpected event: kind %0d code %0d value %0d last %0d",
					seen.kind, seen.code, seen.value, seen.last));
			end else begin
				want = pending_events.pop_front();
				if (seen !== want) begin
					note_failure($sformatf({"event %0d: expected kind %0d code %0d value %0d ",
						"last %0d, got kind %0d code %0d value %0d last %0d"},
						events_checked, want.kind, want.code, want.value, want.last,
						seen.kind, seen.code, seen.value, seen.last));
				end
			end
			events_checked++;
		end
	end

	// Stops a hung run.
	initial begin : watchdog
		#4_000_000;
		$display("watch_report_to_input_events verification failed");
		$finish;
	end

	initial begin : main_sequence
		arst_n             = 1'b0;
		rpt_if.valid       = 1'b0;
		rpt_if.status_code = '0;
		rpt_if.axis_y_raw  = '0;
		rpt_if.axis_x_raw  = '0;
		rpt_if.axis_z_raw  = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = '0;
		cfg_if.data        = '0;
		pred_cfg.abs_mode  = 1'b0;
		pred_cfg.swap_x_z  = 1'b0;
		pred_cfg.gain_x    = GAIN_ONE;
		pred_cfg.gain_y    = GAIN_ONE;
		pred_cfg.gain_z    = GAIN_ONE;
		held_btn = BTN_NONE;
		deb_cnt  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_mouse_defaults();
		test_joystick_axes();
		test_mouse_gains();
		test_unknown_code();
		test_random_traffic();
		test_pressure();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d reports and %0d event beats in mouse and joystick modes,",
			reports_sent, events_checked);
		$display("with presses, releases, debounce, gain extremes and long stalls; %0d errors.",
			mismatch_count);
		if (mismatch_count == 0 && pending_events.size() == 0) begin
			$display("watch_report_to_input_events verification clean");
		end else begin
			$display("watch_report_to_input_events verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wrbe_pkg.sv
sv/wrbe_if.sv
sv/wrbe_front.sv
sv/wrbe_queue.sv
sv/wrbe_back.sv
sv/watch_report_to_input_events.sv
sv/wrbe_checker.sv
test/tb_watch_report_to_input_events.sv
